// ----- src/sma_pkg.sv -----
// ----------------------------------------------------------------------------
// sma_pkg
// Shared codes, types and helpers of the small matrix ALU.
// ----------------------------------------------------------------------------
package sma_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_INV_A = 3'd4;
  localparam logic [2:0] OP_INV_B = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHAPE    = 2'd1;
  localparam logic [1:0] ST_SINGULAR = 2'd2;
  localparam logic [1:0] ST_NOT_SQ   = 2'd3;

  localparam logic [2:0] REG_ROWS_A = 3'd0;
  localparam logic [2:0] REG_COLS_A = 3'd1;
  localparam logic [2:0] REG_ROWS_B = 3'd2;
  localparam logic [2:0] REG_COLS_B = 3'd3;
  localparam logic [2:0] REG_OP     = 3'd4;

  localparam logic [2:0] INV_DIM_MAX = 3'd3;
  localparam word_t      Q_ONE       = 32'sh0001_0000;
  localparam int         DIV_STEPS   = 48;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input word_t v);
    logic [31:0] u;
    u = v;
    return u[31] ? (~u + 32'd1) : u;
  endfunction

endpackage

// ----- src/small_matrix_alu.sv -----
// ----------------------------------------------------------------------------
// small_matrix_alu
// Matrix add, sub, multiply, divide and cofactor inverse up to 3x3 on Q16.16 data.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): load requests write one element of
// A or B and leave in_ready_o high. A start request runs the operation in op_q
// and holds in_ready_o low until its last result is handed to the output
// register. Results leave in row-major order on out_valid_o/out_ready_i; a
// stalled receiver freezes the sequencer, nothing is dropped.
// Work per start request is paced by the single read port of each store,
// one shared 32x32 multiplier and a 48-step radix-2 divider:
//   add/sub : one read of A and B per element
//   mul     : one multiply-accumulate term per row of B, per element
//   det/inv : adjugate and determinant first, then one division per element
//   div     : adjugate of B, then one division and one term per row of B, per element
// Configuration writes are registered; issue them only while no request
// is in flight.
// Reset restores 1x1 shapes, op add and a zero determinant; the stores hold
// whatever was loaded, with no clearing pass.
// ----------------------------------------------------------------------------
module small_matrix_alu #(
  parameter int MAX_DIM = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [1:0]    row_i,
  input  logic [1:0]    col_i,
  input  sma_pkg::word_t value_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    out_row_o,
  output logic [1:0]    out_col_o,
  output sma_pkg::word_t out_value_o,
  output logic          is_det_o,
  output logic [1:0]    status_o,
  output logic          last_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [2:0]    cfg_wdata_i
);
  import sma_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_AS_RD, S_AS_OUT, S_ADJ1_RD, S_ADJ1_CAP, S_ADJ2_RD,
    S_ADJ2_CAP, S_T_RX, S_T_RY, S_T_CY, S_T_MUL, S_T_ACC, S_MIN_DONE,
    S_DET_DONE, S_CHECK, S_DET_OUT, S_INV_START, S_INV_WAIT, S_INV_OUT,
    S_MAC_OUT
  } state_e;

  typedef enum logic [2:0] {
    MD_MIN2, MD_MIN3, MD_DET3, MD_MUL, MD_DIV, MD_INV
  } mode_e;

  function automatic logic [AW-1:0] addr_of(input logic [2:0] r, input logic [2:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // configuration
  logic [2:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q, op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= 3'd1;
      cols_a_q <= 3'd1;
      rows_b_q <= 3'd1;
      cols_b_q <= 3'd1;
      op_q     <= OP_ADD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_A: rows_a_q <= cfg_wdata_i;
        REG_COLS_A: cols_a_q <= cfg_wdata_i;
        REG_ROWS_B: rows_b_q <= cfg_wdata_i;
        REG_COLS_B: cols_b_q <= cfg_wdata_i;
        REG_OP:     op_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // state
  state_e state_q;
  mode_e  mode_q;
  logic [2:0] i_q, j_q, k_q;
  logic [1:0] n_q;
  logic       msel_b_q;
  logic [1:0] err_status_q;
  logic       err_isdet_q;
  word_t      det_q, x_q, y_q;
  logic signed [63:0] acc_q, prod_q;

  logic       out_valid_q, is_det_q, last_q;
  logic [1:0] out_row_q, out_col_q, status_q;
  word_t      out_value_q;

  word_t cof_q [9];

  // stores
  logic          ram_re;
  logic [AW-1:0] ram_raddr, wr_addr;
  logic          wr_a, wr_b, ld_ok, accept;
  word_t         rd_a, rd_b, rd_m;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ld_ok      = accept && (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign wr_a       = ld_ok && (kind_i == KIND_LOAD_A);
  assign wr_b       = ld_ok && (kind_i == KIND_LOAD_B);
  assign wr_addr    = addr_of({1'b0, row_i}, {1'b0, col_i});
  assign rd_m       = msel_b_q ? rd_b : rd_a;

  sma_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram_a (
    .clk_i, .we_i(wr_a), .waddr_i(wr_addr), .wdata_i(value_i),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(rd_a)
  );

  sma_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram_b (
    .clk_i, .we_i(wr_b), .waddr_i(wr_addr), .wdata_i(value_i),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(rd_b)
  );

  // term operand selection
  logic [2:0] x_row, x_col, y_row, y_col, r0, r1, c0, c1;
  logic       x_from_b, y_from_b, sub_term;

  always_comb begin
    r0 = (j_q == 3'd0) ? 3'd1 : 3'd0;
    r1 = (j_q == 3'd2) ? 3'd1 : 3'd2;
    c0 = (i_q == 3'd0) ? 3'd1 : 3'd0;
    c1 = (i_q == 3'd2) ? 3'd1 : 3'd2;
    x_row    = i_q;
    x_col    = k_q;
    y_row    = k_q;
    y_col    = j_q;
    x_from_b = 1'b0;
    y_from_b = 1'b1;
    sub_term = 1'b0;
    unique case (mode_q)
      MD_MIN2: begin
        x_row    = 3'd0;
        x_col    = {2'd0, k_q[0]};
        y_row    = 3'd1;
        y_col    = {2'd0, ~k_q[0]};
        x_from_b = msel_b_q;
        y_from_b = msel_b_q;
        sub_term = k_q[0];
      end
      MD_MIN3: begin
        x_row    = r0;
        x_col    = k_q[0] ? c1 : c0;
        y_row    = r1;
        y_col    = k_q[0] ? c0 : c1;
        x_from_b = msel_b_q;
        y_from_b = msel_b_q;
        sub_term = k_q[0];
      end
      MD_DET3: begin
        x_row    = k_q;
        x_col    = 3'd0;
        x_from_b = msel_b_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr_of(x_row, x_col);
    unique case (state_q)
      S_AS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(i_q, j_q);
      end
      S_ADJ1_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(3'd0, 3'd0);
      end
      S_ADJ2_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(3'(3'd1 - j_q), 3'(3'd1 - i_q));
      end
      S_T_RX: ram_re = 1'b1;
      S_T_RY: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(y_row, y_col);
      end
      default: ;
    endcase
  end

  // cofactor registers
  logic [3:0] ij_idx, cof_ridx;
  logic       cof_we;
  word_t      cof_wd;

  assign ij_idx = 4'(int'(i_q) * 3 + int'(j_q));

  always_comb begin
    cof_ridx = ij_idx;
    if (mode_q == MD_DET3) begin
      cof_ridx = {1'b0, k_q};
    end else if (mode_q == MD_DIV) begin
      cof_ridx = 4'(int'(k_q) * 3 + int'(j_q));
    end
  end

  always_comb begin
    cof_we = 1'b0;
    cof_wd = rd_m;
    unique case (state_q)
      S_ADJ1_CAP: begin
        cof_we = 1'b1;
        cof_wd = Q_ONE;
      end
      S_ADJ2_CAP: begin
        cof_we = 1'b1;
        cof_wd = (i_q[0] ^ j_q[0]) ? sat32(-64'(rd_m)) : rd_m;
      end
      S_MIN_DONE: begin
        cof_we = (mode_q == MD_MIN3);
        cof_wd = sat32((i_q[0] ^ j_q[0]) ? -acc_q : acc_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cof_we) begin
      cof_q[ij_idx] <= cof_wd;
    end
  end

  // radix-2 divider: cofactor * 2^16 / det, truncated toward zero
  logic [5:0]  div_cnt_q;
  logic [31:0] div_rem_q, div_den_q, rem_nx;
  logic [47:0] div_quo_q;
  logic        div_neg_q, div_start, fits;
  logic [32:0] rem_sh;
  word_t       div_num, div_res;

  assign div_start = ((state_q == S_T_RX) && (mode_q == MD_DIV)) || (state_q == S_INV_START);
  assign div_num   = cof_q[cof_ridx];
  assign rem_sh    = {div_rem_q, div_quo_q[47]};
  assign fits      = rem_sh >= {1'b0, div_den_q};
  assign rem_nx    = fits ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];

  always_comb begin
    if (div_neg_q) begin
      div_res = (div_quo_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : ~div_quo_q[31:0] + 32'd1;
    end else begin
      div_res = (div_quo_q > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : div_quo_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_den_q <= '0;
      div_quo_q <= '0;
      div_neg_q <= 1'b0;
    end else if (div_start) begin
      div_cnt_q <= 6'(DIV_STEPS);
      div_rem_q <= '0;
      div_quo_q <= {mag32(div_num), 16'd0};
      div_den_q <= mag32(det_q);
      div_neg_q <= div_num[31] ^ det_q[31];
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 6'd1;
      div_rem_q <= rem_nx;
      div_quo_q <= {div_quo_q[46:0], fits};
    end
  end

  // start decode
  logic dims_ok, sq_ok, b_sq_ok, can_emit;
  logic [2:0] sel_r, sel_c;
  logic [1:0] adj_n;
  logic signed [63:0] term, acc_nx, mul_res, as_sum;

  assign dims_ok = (rows_a_q != 3'd0) && (int'(rows_a_q) <= MAX_DIM) &&
                   (cols_a_q != 3'd0) && (int'(cols_a_q) <= MAX_DIM) &&
                   (rows_b_q != 3'd0) && (int'(rows_b_q) <= MAX_DIM) &&
                   (cols_b_q != 3'd0) && (int'(cols_b_q) <= MAX_DIM);
  assign sel_r   = (op_q == OP_INV_A) ? rows_a_q : rows_b_q;
  assign sel_c   = (op_q == OP_INV_A) ? cols_a_q : cols_b_q;
  assign sq_ok   = (sel_r != 3'd0) && (sel_r == sel_c) && (sel_r <= INV_DIM_MAX);
  assign b_sq_ok = (rows_b_q == cols_b_q) && (rows_b_q <= INV_DIM_MAX);
  assign adj_n   = (op_q == OP_DIV) ? rows_b_q[1:0] : sel_r[1:0];
  assign can_emit = !out_valid_q || out_ready_i;

  assign mul_res = x_q * y_q;
  assign term    = prod_q >>> 16;
  assign acc_nx  = ((k_q == 3'd0) ? 64'sd0 : acc_q) + (sub_term ? -term : term);
  assign as_sum  = (op_q == OP_SUB) ? (64'(rd_a) - 64'(rd_b)) : (64'(rd_a) + 64'(rd_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MD_MUL;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      n_q          <= '0;
      msel_b_q     <= 1'b0;
      err_status_q <= ST_OK;
      err_isdet_q  <= 1'b0;
      det_q        <= '0;
      x_q          <= '0;
      y_q          <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_value_q  <= '0;
      is_det_q     <= 1'b0;
      status_q     <= ST_OK;
      last_q       <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (accept && kind_i == KIND_START) begin
            err_isdet_q <= 1'b0;
            err_status_q <= ST_SHAPE;
            msel_b_q <= (op_q != OP_INV_A);
            n_q <= adj_n;
            mode_q <= MD_MIN3;
            case (op_q) inside
              OP_ADD, OP_SUB: begin
                if (!dims_ok || rows_a_q != rows_b_q || cols_a_q != cols_b_q) begin
                  state_q <= S_ERR;
                end else begin
                  state_q <= S_AS_RD;
                end
              end
              OP_MUL: begin
                mode_q  <= MD_MUL;
                state_q <= (!dims_ok || cols_a_q != rows_b_q) ? S_ERR : S_T_RX;
              end
              OP_DIV: begin
                if (!dims_ok || cols_a_q != rows_b_q) begin
                  state_q <= S_ERR;
                end else if (!b_sq_ok) begin
                  err_status_q <= ST_NOT_SQ;
                  state_q      <= S_ERR;
                end else begin
                  state_q <= (adj_n == 2'd1) ? S_ADJ1_RD :
                             (adj_n == 2'd2) ? S_ADJ2_RD : S_T_RX;
                end
              end
              OP_INV_A, OP_INV_B: begin
                if (!sq_ok) begin
                  err_status_q <= ST_NOT_SQ;
                  state_q      <= S_ERR;
                end else begin
                  state_q <= (adj_n == 2'd1) ? S_ADJ1_RD :
                             (adj_n == 2'd2) ? S_ADJ2_RD : S_T_RX;
                end
              end
              default: ;
            endcase
          end
        end
        S_ERR: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_row_q   <= '0;
            out_col_q   <= '0;
            out_value_q <= '0;
            is_det_q    <= err_isdet_q;
            status_q    <= err_status_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_AS_RD: state_q <= S_AS_OUT;
        S_AS_OUT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_row_q   <= i_q[1:0];
            out_col_q   <= j_q[1:0];
            out_value_q <= sat32(as_sum);
            is_det_q    <= 1'b0;
            status_q    <= ST_OK;
            last_q      <= (3'(i_q + 3'd1) == rows_a_q) && (3'(j_q + 3'd1) == cols_a_q);
            state_q     <= S_AS_RD;
            if (3'(j_q + 3'd1) == cols_a_q) begin
              j_q <= '0;
              i_q <= 3'(i_q + 3'd1);
              if (3'(i_q + 3'd1) == rows_a_q) begin
                state_q <= S_IDLE;
              end
            end else begin
              j_q <= 3'(j_q + 3'd1);
            end
          end
        end
        S_ADJ1_RD: state_q <= S_ADJ1_CAP;
        S_ADJ1_CAP: begin
          det_q   <= rd_m;
          state_q <= S_CHECK;
        end
        S_ADJ2_RD: state_q <= S_ADJ2_CAP;
        S_ADJ2_CAP: begin
          state_q <= S_ADJ2_RD;
          if (j_q == 3'd1) begin
            j_q <= '0;
            if (i_q == 3'd1) begin
              i_q     <= '0;
              k_q     <= '0;
              mode_q  <= MD_MIN2;
              state_q <= S_T_RX;
            end else begin
              i_q <= 3'd1;
            end
          end else begin
            j_q <= 3'd1;
          end
        end
        S_T_RX: state_q <= S_T_RY;
        S_T_RY: begin
          x_q     <= x_from_b ? rd_b : rd_a;
          state_q <= S_T_CY;
        end
        S_T_CY: begin
          if (mode_q == MD_DIV) begin
            if (div_cnt_q == '0) begin
              y_q     <= div_res;
              state_q <= S_T_MUL;
            end
          end else begin
            y_q     <= (mode_q == MD_DET3) ? cof_q[cof_ridx] : (y_from_b ? rd_b : rd_a);
            state_q <= S_T_MUL;
          end
        end
        S_T_MUL: begin
          prod_q  <= mul_res;
          state_q <= S_T_ACC;
        end
        S_T_ACC: begin
          acc_q   <= acc_nx;
          state_q <= S_T_RX;
          k_q     <= 3'(k_q + 3'd1);
          case (mode_q) inside
            MD_MIN2, MD_MIN3: begin
              if (k_q != 3'd0) begin
                state_q <= S_MIN_DONE;
              end
            end
            MD_DET3: begin
              if (k_q == 3'd2) begin
                state_q <= S_DET_DONE;
              end
            end
            default: begin
              if (3'(k_q + 3'd1) == rows_b_q) begin
                state_q <= S_MAC_OUT;
              end
            end
          endcase
        end
        S_MIN_DONE: begin
          k_q     <= '0;
          state_q <= S_T_RX;
          if (mode_q == MD_MIN2) begin
            det_q   <= sat32(acc_q);
            state_q <= S_CHECK;
          end else if (j_q == 3'd2) begin
            j_q <= '0;
            if (i_q == 3'd2) begin
              i_q    <= '0;
              mode_q <= MD_DET3;
            end else begin
              i_q <= 3'(i_q + 3'd1);
            end
          end else begin
            j_q <= 3'(j_q + 3'd1);
          end
        end
        S_DET_DONE: begin
          det_q   <= sat32(acc_q);
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (det_q == '0) begin
            err_status_q <= ST_SINGULAR;
            err_isdet_q  <= (op_q != OP_DIV);
            state_q      <= S_ERR;
          end else if (op_q == OP_DIV) begin
            mode_q  <= MD_DIV;
            state_q <= S_T_RX;
          end else begin
            mode_q  <= MD_INV;
            state_q <= S_DET_OUT;
          end
        end
        S_DET_OUT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_row_q   <= '0;
            out_col_q   <= '0;
            out_value_q <= det_q;
            is_det_q    <= 1'b1;
            status_q    <= ST_OK;
            last_q      <= 1'b0;
            state_q     <= S_INV_START;
          end
        end
        S_INV_START: state_q <= S_INV_WAIT;
        S_INV_WAIT: begin
          if (div_cnt_q == '0) begin
            state_q <= S_INV_OUT;
          end
        end
        S_INV_OUT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_row_q   <= i_q[1:0];
            out_col_q   <= j_q[1:0];
            out_value_q <= div_res;
            is_det_q    <= 1'b0;
            status_q    <= ST_OK;
            last_q      <= (i_q[1:0] == 2'(n_q - 2'd1)) && (j_q[1:0] == 2'(n_q - 2'd1));
            state_q     <= S_INV_START;
            if (j_q[1:0] == 2'(n_q - 2'd1)) begin
              j_q <= '0;
              i_q <= 3'(i_q + 3'd1);
              if (i_q[1:0] == 2'(n_q - 2'd1)) begin
                state_q <= S_IDLE;
              end
            end else begin
              j_q <= 3'(j_q + 3'd1);
            end
          end
        end
        S_MAC_OUT: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_row_q   <= i_q[1:0];
            out_col_q   <= j_q[1:0];
            out_value_q <= sat32(acc_q);
            is_det_q    <= 1'b0;
            status_q    <= ST_OK;
            last_q      <= (3'(i_q + 3'd1) == rows_a_q) && (3'(j_q + 3'd1) == cols_b_q);
            k_q         <= '0;
            state_q     <= S_T_RX;
            if (3'(j_q + 3'd1) == cols_b_q) begin
              j_q <= '0;
              i_q <= 3'(i_q + 3'd1);
              if (3'(i_q + 3'd1) == rows_a_q) begin
                state_q <= S_IDLE;
              end
            end else begin
              j_q <= 3'(j_q + 3'd1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign is_det_o    = is_det_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// ----- src/sma_ram.sv -----
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the small matrix ALU.
// Loads A and B, runs every operation under many shapes and checks each
// result element against a fixed-point predictor, with random idling on the
// request and result channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sma_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] row;
    logic [1:0] col;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] r;
    logic [1:0] c;
    logic [31:0] v;
    logic d;
    logic [1:0] st;
    logic lst;
  } res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [1:0] kind_i, row_i, col_i;
  word_t value_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] out_row_o, out_col_o;
  word_t out_value_o;
  logic is_det_o, last_o;
  logic [1:0] status_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i, cfg_wdata_i;

  small_matrix_alu DUT (.*);

  req_t req_q[$];
  res_t expected_res_q[$];
  req_t cur_req;
  bit req_taken;
  int in_idle_pct, out_stall_pct;
  int hold_left;
  int mismatches;
  int req_count;

  // predictor state
  logic [2:0] m_rows_a, m_cols_a, m_rows_b, m_cols_b, m_op;
  int mat_a[16];
  int mat_b[16];
  int adj[9];
  int det_val;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic longint mul_q(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic int elem(bit from_b, int r, int c);
    return from_b ? mat_b[r * 4 + c] : mat_a[r * 4 + c];
  endfunction

  function automatic bit dim_good(logic [2:0] d);
    return d >= 1 && d <= 4;
  endfunction

  function automatic void build_adjugate(bit from_b, int n);
    longint acc, mn;
    int r0, r1, c0, c1;
    foreach (adj[i]) adj[i] = 0;
    if (n == 1) begin
      adj[0] = Q_ONE;
      det_val = elem(from_b, 0, 0);
    end else if (n == 2) begin
      adj[0] = elem(from_b, 1, 1);
      adj[1] = clip32(-longint'(elem(from_b, 0, 1)));
      adj[3] = clip32(-longint'(elem(from_b, 1, 0)));
      adj[4] = elem(from_b, 0, 0);
      det_val = clip32(mul_q(elem(from_b, 0, 0), elem(from_b, 1, 1)) -
                       mul_q(elem(from_b, 0, 1), elem(from_b, 1, 0)));
    end else begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          r0 = (c == 0) ? 1 : 0;
          r1 = (c == 2) ? 1 : 2;
          c0 = (r == 0) ? 1 : 0;
          c1 = (r == 2) ? 1 : 2;
          mn = mul_q(elem(from_b, r0, c0), elem(from_b, r1, c1)) -
               mul_q(elem(from_b, r0, c1), elem(from_b, r1, c0));
          if ((r + c) % 2 == 1) mn = -mn;
          adj[r * 3 + c] = clip32(mn);
        end
      end
      for (int k = 0; k < 3; k++) acc += mul_q(elem(from_b, k, 0), adj[k]);
      det_val = clip32(acc);
    end
  endfunction

  function automatic int inverse_elem(int r, int c);
    return clip32((longint'(adj[r * 3 + c]) * 65536) / longint'(det_val));
  endfunction

  function automatic void push_result(int r, int c, int v, bit d, logic [1:0] st,
                                      bit lst);
    res_t e;
    e.r = r[1:0];
    e.c = c[1:0];
    e.v = v;
    e.d = d;
    e.st = st;
    e.lst = lst;
    expected_res_q.push_back(e);
  endfunction

  function automatic void compute_results(req_t q);
    bit dims;
    int ra, ca, rb, cb, n;
    longint acc;
    bit from_b;
    logic [2:0] rr, cc;
    dims = dim_good(m_rows_a) && dim_good(m_cols_a) && dim_good(m_rows_b) &&
           dim_good(m_cols_b);
    ra = m_rows_a;
    ca = m_cols_a;
    rb = m_rows_b;
    cb = m_cols_b;
    if (q.kind == KIND_LOAD_A) begin
      mat_a[q.row * 4 + q.col] = q.value;
      return;
    end
    if (q.kind == KIND_LOAD_B) begin
      mat_b[q.row * 4 + q.col] = q.value;
      return;
    end
    if (q.kind != KIND_START || m_op > OP_INV_B) return;
    if (m_op == OP_ADD || m_op == OP_SUB) begin
      if (!dims || ra != rb || ca != cb) begin
        push_result(0, 0, 0, 0, ST_SHAPE, 1);
        return;
      end
      for (int i = 0; i < ra; i++)
        for (int j = 0; j < ca; j++)
          push_result(i, j, clip32((m_op == OP_SUB) ?
                        longint'(mat_a[i * 4 + j]) - longint'(mat_b[i * 4 + j]) :
                        longint'(mat_a[i * 4 + j]) + longint'(mat_b[i * 4 + j])),
                      0, ST_OK, i == ra - 1 && j == ca - 1);
      return;
    end
    if (m_op == OP_MUL || m_op == OP_DIV) begin
      if (!dims || ca != rb) begin
        push_result(0, 0, 0, 0, ST_SHAPE, 1);
        return;
      end
      if (m_op == OP_DIV) begin
        if (rb != cb || rb > 3) begin
          push_result(0, 0, 0, 0, ST_NOT_SQ, 1);
          return;
        end
        build_adjugate(1, rb);
        if (det_val == 0) begin
          push_result(0, 0, 0, 0, ST_SINGULAR, 1);
          return;
        end
      end
      for (int i = 0; i < ra; i++)
        for (int j = 0; j < cb; j++) begin
          acc = 0;
          for (int k = 0; k < rb; k++)
            acc += mul_q(mat_a[i * 4 + k],
                         (m_op == OP_MUL) ? mat_b[k * 4 + j] : inverse_elem(k, j));
          push_result(i, j, clip32(acc), 0, ST_OK, i == ra - 1 && j == cb - 1);
        end
      return;
    end
    from_b = (m_op == OP_INV_B);
    rr = from_b ? m_rows_b : m_rows_a;
    cc = from_b ? m_cols_b : m_cols_a;
    if (!dim_good(rr) || rr != cc || rr > INV_DIM_MAX) begin
      push_result(0, 0, 0, 0, ST_NOT_SQ, 1);
      return;
    end
    n = rr;
    build_adjugate(from_b, n);
    if (det_val == 0) begin
      push_result(0, 0, 0, 1, ST_SINGULAR, 1);
      return;
    end
    push_result(0, 0, det_val, 1, ST_OK, 0);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        push_result(i, j, inverse_elem(i, j), 0, ST_OK, i == n - 1 && j == n - 1);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!in_valid_i || req_taken) begin
      req_taken = 0;
      if (req_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        cur_req = req_q.pop_front();
        kind_i <= cur_req.kind;
        row_i <= cur_req.row;
        col_i <= cur_req.col;
        value_i <= cur_req.value;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      compute_results(cur_req);
      req_taken = 1;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= out_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value %h", out_value_o);
      end else begin
        e = expected_res_q.pop_front();
        if (out_row_o !== e.r || out_col_o !== e.c || out_value_o !== e.v ||
            is_det_o !== e.d || status_o !== e.st || last_o !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r%0d c%0d v%h d%b s%0d l%b got r%0d c%0d v%h d%b s%0d l%b",
                     e.r, e.c, e.v, e.d, e.st, e.lst, out_row_o, out_col_o,
                     out_value_o, is_det_o, status_o, last_o);
        end
      end
    end
  end

  function automatic int rand_value();
    int v;
    if ($urandom_range(3) == 0) return $urandom;
    v = $urandom_range(6 * 65536);
    return v - 3 * 65536;
  endfunction

  task automatic add_req(logic [1:0] kind, int r, int c, int v);
    req_t q;
    q.kind = kind;
    q.row = r[1:0];
    q.col = c[1:0];
    q.value = v;
    req_q.push_back(q);
    req_count++;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_valid_i || expected_res_q.size() > 0)
      @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_ROWS_A: m_rows_a = val;
      REG_COLS_A: m_cols_a = val;
      REG_ROWS_B: m_rows_b = val;
      REG_COLS_B: m_cols_b = val;
      default: m_op = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_shape(int ra, int ca, int rb, int cb, logic [2:0] op);
    drain();
    write_reg(REG_ROWS_A, ra[2:0]);
    write_reg(REG_COLS_A, ca[2:0]);
    write_reg(REG_ROWS_B, rb[2:0]);
    write_reg(REG_COLS_B, cb[2:0]);
    write_reg(REG_OP, op);
  endtask

  task automatic load_used(int ra, int ca, int rb, int cb, int pct);
    for (int i = 0; i < ra && i < 4; i++)
      for (int j = 0; j < ca && j < 4; j++)
        if ($urandom_range(99) < pct) add_req(KIND_LOAD_A, i, j, rand_value());
    for (int i = 0; i < rb && i < 4; i++)
      for (int j = 0; j < cb && j < 4; j++)
        if ($urandom_range(99) < pct) add_req(KIND_LOAD_B, i, j, rand_value());
  endtask

  function automatic int pick_dim();
    int p;
    p = $urandom_range(99);
    if (p < 4) return 0;
    if (p < 8) return $urandom_range(7, 5);
    if (p < 20) return 4;
    return $urandom_range(3, 1);
  endfunction

  initial begin
    int mode, ra, ca, rb, cb, sq;
    logic [2:0] op;
    in_valid_i = 0;
    kind_i = 0;
    row_i = 0;
    col_i = 0;
    value_i = 0;
    out_ready_i = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_wdata_i = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 0;
    mismatches = 0;
    req_count = 0;
    m_rows_a = 1;
    m_cols_a = 1;
    m_rows_b = 1;
    m_cols_b = 1;
    m_op = OP_ADD;
    det_val = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // fill both stores, field extremes included
    for (int i = 0; i < 16; i++) begin
      add_req(KIND_LOAD_A, i / 4, i % 4, (i == 0) ? 32'h7fff_ffff :
              (i == 1) ? 32'h8000_0000 : rand_value());
      add_req(KIND_LOAD_B, i / 4, i % 4, (i == 0) ? 32'h8000_0000 :
              (i == 1) ? 32'hffff_ffff : rand_value());
    end
    add_req(KIND_START, 0, 0, 0);
    add_req(2'd3, 3, 3, 32'h1234_5678);
    set_shape(4, 4, 4, 4, OP_ADD);
    add_req(KIND_START, 0, 0, 0);
    set_shape(4, 4, 4, 4, OP_SUB);
    add_req(KIND_START, 0, 0, 0);
    set_shape(4, 4, 4, 4, OP_MUL);
    add_req(KIND_START, 0, 0, 0);
    set_shape(4, 4, 4, 4, OP_INV_A);
    add_req(KIND_START, 0, 0, 0);
    set_shape(2, 3, 3, 3, OP_DIV);
    load_used(2, 3, 3, 3, 100);
    add_req(KIND_START, 0, 0, 0);
    set_shape(3, 3, 2, 2, OP_INV_A);
    add_req(KIND_START, 0, 0, 0);
    set_shape(3, 3, 2, 2, OP_INV_B);
    add_req(KIND_START, 0, 0, 0);
    set_shape(1, 1, 1, 1, OP_INV_A);
    add_req(KIND_START, 0, 0, 0);
    set_shape(0, 1, 1, 1, OP_INV_A);
    add_req(KIND_START, 0, 0, 0);
    set_shape(7, 7, 7, 7, OP_ADD);
    add_req(KIND_START, 0, 0, 0);
    set_shape(2, 2, 3, 3, OP_SUB);
    add_req(KIND_START, 0, 0, 0);
    set_shape(2, 2, 3, 3, 3'd6);
    add_req(KIND_START, 0, 0, 0);
    set_shape(2, 2, 2, 2, 3'd7);
    add_req(KIND_START, 0, 0, 0);
    // singular inverse and singular divide with a zero matrix
    set_shape(2, 2, 2, 2, OP_INV_A);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        add_req(KIND_LOAD_A, i, j, 0);
        add_req(KIND_LOAD_B, i, j, 0);
      end
    add_req(KIND_START, 0, 0, 0);
    set_shape(2, 2, 2, 2, OP_DIV);
    add_req(KIND_START, 0, 0, 0);

    mode = 0;
    while (req_count < 340) begin
      ra = pick_dim();
      ca = pick_dim();
      rb = pick_dim();
      cb = pick_dim();
      op = $urandom_range(99) < 6 ? $urandom_range(7, 6) : $urandom_range(5);
      sq = $urandom_range(3);
      // bias toward shapes that reach the arithmetic
      if (op <= OP_SUB && $urandom_range(3) != 0) begin
        rb = ra;
        cb = ca;
      end else if (op == OP_MUL && $urandom_range(3) != 0) begin
        rb = ca;
      end else if (op == OP_DIV && $urandom_range(3) != 0) begin
        rb = $urandom_range(3, 1);
        cb = rb;
        ca = rb;
      end else if (op >= OP_INV_A && $urandom_range(3) != 0) begin
        ra = $urandom_range(3, 1);
        ca = ra;
        rb = $urandom_range(3, 1);
        cb = rb;
      end
      set_shape(ra, ca, rb, cb, op);
      case (mode % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 77; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 77; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      mode++;
      if (mode == 6) hold_left = 400;
      for (int s = 0; s <= sq; s++) begin
        load_used(ra, ca, rb, cb, 70);
        if ($urandom_range(9) == 0)
          add_req($urandom_range(3), $urandom_range(3), $urandom_range(3), $urandom);
        add_req(KIND_START, 0, 0, 0);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (expected_res_q.size() > 0) mismatches++;
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sma_pkg.sv
src/sma_ram.sv
src/small_matrix_alu.sv
test/tb_top.sv
